FILE: rtl/ec_point_scalar_multiply_core_defines.svh
// Assertion macros shared by the elliptic-curve scalar multiply RTL.
`ifndef EC_POINT_SCALAR_MULTIPLY_CORE_DEFINES_SVH
`define EC_POINT_SCALAR_MULTIPLY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define ECSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the following cycle.
`define ECSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECSM_ASSERT_IMP(lbl, ante, cons, msg)
`define ECSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/ecsm_pkg.sv
// Types, codes and modular helpers for the elliptic-curve scalar multiply core.
package ecsm_pkg;

    localparam int FIELD_BITS = 16;

    typedef logic [FIELD_BITS-1:0] fe_t;

    // Serial unit operation codes.
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_INF  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_PRIME_P = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } su_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } su_rsp_t;

    // Modular addition of two values already below m.
    function automatic fe_t add_m(input fe_t x, input fe_t y, input fe_t m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    // Modular subtraction of two values already below m.
    function automatic fe_t sub_m(input fe_t x, input fe_t y, input fe_t m);
        fe_t d;
        if (x >= y)
        begin
            d = x - y;
        end
        else
        begin
            d = m - (y - x);
        end
        return d;
    endfunction

endpackage

FILE: rtl/ecsm_serial_unit.sv
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
module ecsm_serial_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  ecsm_pkg::su_req_t req,
    input  ecsm_pkg::fe_t     op_a,
    input  ecsm_pkg::fe_t     op_b,
    input  ecsm_pkg::fe_t     modulus,
    output ecsm_pkg::su_rsp_t rsp,
    output ecsm_pkg::fe_t     quot,
    output ecsm_pkg::fe_t     rem
);

    localparam int W  = ecsm_pkg::FIELD_BITS;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    ecsm_pkg::fe_t acc_reg, acc_next;
    ecsm_pkg::fe_t shf_reg, shf_next;
    ecsm_pkg::fe_t a_reg, a_next;
    ecsm_pkg::fe_t b_reg, b_next;
    ecsm_pkg::fe_t m_reg, m_next;

    // One step of double-and-add or of shift-and-subtract per cycle.
    always_comb
    begin
        logic [W:0]    trial;
        ecsm_pkg::fe_t dbl;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        shf_next  = shf_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        trial     = {acc_reg, shf_reg[W-1]};
        dbl       = ecsm_pkg::add_m(acc_reg, acc_reg, m_reg);
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            shf_next  = (req.op == ecsm_pkg::OP_DIV) ? op_a : op_b;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
        end
        else if (busy_reg)
        begin
            if (op_reg == ecsm_pkg::OP_MUL)
            begin
                acc_next = shf_reg[W-1] ? ecsm_pkg::add_m(dbl, a_reg, m_reg) : dbl;
                shf_next = {shf_reg[W-2:0], 1'b0};
            end
            else
            begin
                if (trial >= {1'b0, b_reg})
                begin
                    trial    = trial - {1'b0, b_reg};
                    shf_next = {shf_reg[W-2:0], 1'b1};
                end
                else
                begin
                    shf_next = {shf_reg[W-2:0], 1'b0};
                end
                acc_next = trial[W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        shf_reg <= shf_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quot     = shf_reg;
    assign rem      = acc_reg;

endmodule

FILE: rtl/ec_point_scalar_multiply_core.sv
// Top level of the affine elliptic-curve scalar multiply core over GF(p).
// Usage: write curve_a (index 0) and prime_p (index 1) on the cfg channel while idle;
// cfg_ready is always high. Send one point and scalar per s_tdata transfer; one
// result comes out per transfer on m_tdata with its status on m_tuser.
// The core forms n*P by adding P to the running sum n-1 times, one point at a time.
// Every modular product, quotient and remainder runs on one bit-serial unit. Each
// point addition costs three products plus an extended Euclid inverse of k steps
// (a check, a division and a product each), with k at most about 23; a doubling
// adds one product more.
// One item is worked on at a time; s_tready is high whenever the core is idle,
// even while an earlier result still waits on m_tready.
// A finished result waits in the output register while m_tready is low, and the
// next computation stalls at its end until that register is free.
// Reset clears the handshakes, sets curve_a to 0 and prime_p to 65521.
// A prime_p below 3 is used as 3; status 1 means infinity was reached.
`include "ec_point_scalar_multiply_core_defines.svh"
module ec_point_scalar_multiply_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x [15:0], point_y [31:16], scalar [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_x [15:0], result_y [31:16]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED_A   = 4'd1;
    localparam logic [3:0] S_RED_X   = 4'd2;
    localparam logic [3:0] S_RED_Y   = 4'd3;
    localparam logic [3:0] S_LOOP    = 4'd4;
    localparam logic [3:0] S_DBL_SQ  = 4'd5;
    localparam logic [3:0] S_DBL_A   = 4'd6;
    localparam logic [3:0] S_INV_CHK = 4'd7;
    localparam logic [3:0] S_INV_DIV = 4'd8;
    localparam logic [3:0] S_INV_MUL = 4'd9;
    localparam logic [3:0] S_LAM     = 4'd10;
    localparam logic [3:0] S_LSQ     = 4'd11;
    localparam logic [3:0] S_YMUL    = 4'd12;
    localparam logic [3:0] S_FINISH  = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic          wait_reg, wait_next;
    logic          out_valid_reg, out_valid_next;
    ecsm_pkg::fe_t curve_a_reg, curve_a_next;
    ecsm_pkg::fe_t prime_p_reg, prime_p_next;

    ecsm_pkg::fe_t m_reg, m_next;
    ecsm_pkg::fe_t a_reg, a_next;
    ecsm_pkg::fe_t xin_reg, xin_next;
    ecsm_pkg::fe_t yin_reg, yin_next;
    logic [15:0]   cnt_reg, cnt_next;
    ecsm_pkg::fe_t px_reg, px_next;
    ecsm_pkg::fe_t py_reg, py_next;
    ecsm_pkg::fe_t qx_reg, qx_next;
    ecsm_pkg::fe_t qy_reg, qy_next;
    ecsm_pkg::fe_t num_reg, num_next;
    ecsm_pkg::fe_t r0_reg, r0_next;
    ecsm_pkg::fe_t r1_reg, r1_next;
    ecsm_pkg::fe_t t0_reg, t0_next;
    ecsm_pkg::fe_t t1_reg, t1_next;
    ecsm_pkg::fe_t q_reg, q_next;
    ecsm_pkg::fe_t rr_reg, rr_next;
    ecsm_pkg::fe_t lam_reg, lam_next;
    ecsm_pkg::fe_t x3_reg, x3_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   ox_reg, ox_next;
    logic [15:0]   oy_reg, oy_next;
    logic [1:0]    ost_reg, ost_next;

    ecsm_pkg::su_req_t su_req;
    ecsm_pkg::su_rsp_t su_rsp;
    ecsm_pkg::fe_t     su_a;
    ecsm_pkg::fe_t     su_b;
    ecsm_pkg::fe_t     su_q;
    ecsm_pkg::fe_t     su_r;
    logic              op_state;
    logic              s_fire;
    logic              m_fire;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // Shared serial arithmetic unit.
    ecsm_serial_unit u_serial (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (su_req),
        .op_a    (su_a),
        .op_b    (su_b),
        .modulus (m_reg),
        .rsp     (su_rsp),
        .quot    (su_q),
        .rem     (su_r)
    );

    // Operand selection and request for each arithmetic state.
    always_comb
    begin
        op_state   = 1'b1;
        su_req.op  = ecsm_pkg::OP_MUL;
        su_a       = lam_reg;
        su_b       = lam_reg;
        case (state_reg)
            S_RED_A:
            begin
                su_req.op = ecsm_pkg::OP_DIV;
                su_a      = a_reg;
                su_b      = m_reg;
            end
            S_RED_X:
            begin
                su_req.op = ecsm_pkg::OP_DIV;
                su_a      = xin_reg;
                su_b      = m_reg;
            end
            S_RED_Y:
            begin
                su_req.op = ecsm_pkg::OP_DIV;
                su_a      = yin_reg;
                su_b      = m_reg;
            end
            S_DBL_SQ:
            begin
                su_a = px_reg;
                su_b = px_reg;
            end
            S_INV_DIV:
            begin
                su_req.op = ecsm_pkg::OP_DIV;
                su_a      = r0_reg;
                su_b      = r1_reg;
            end
            S_INV_MUL:
            begin
                su_a = q_reg;
                su_b = t1_reg;
            end
            S_LAM:
            begin
                su_a = num_reg;
                su_b = t0_reg;
            end
            S_LSQ:
            begin
                su_a = lam_reg;
                su_b = lam_reg;
            end
            S_YMUL:
            begin
                su_a = lam_reg;
                su_b = ecsm_pkg::sub_m(qx_reg, x3_reg, m_reg);
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
        su_req.start = op_state && !wait_reg;
    end

    // Sequencer for reduction, point addition and the inverse loop.
    always_comb
    begin
        ecsm_pkg::fe_t t2;
        ecsm_pkg::fe_t qm;
        state_next     = state_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        curve_a_next   = curve_a_reg;
        prime_p_next   = prime_p_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        xin_next       = xin_reg;
        yin_next       = yin_reg;
        cnt_next       = cnt_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        num_next       = num_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        q_next         = q_reg;
        rr_next        = rr_reg;
        lam_next       = lam_reg;
        x3_next        = x3_reg;
        status_next    = status_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ost_next       = ost_reg;
        t2             = ecsm_pkg::add_m(su_r, su_r, m_reg);
        qm             = (su_q >= m_reg) ? (su_q - m_reg) : su_q;

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == ecsm_pkg::CFG_CURVE_A)
            begin
                curve_a_next = cfg_data;
            end
            else
            begin
                prime_p_next = cfg_data;
            end
        end

        // The output register empties on a transfer.
        if (m_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (su_req.start)
        begin
            wait_next = 1'b1;
        end
        if (su_rsp.done)
        begin
            wait_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    xin_next   = s_tdata[15:0];
                    yin_next   = s_tdata[31:16];
                    cnt_next   = s_tdata[47:32];
                    m_next     = (prime_p_reg < 16'd3) ? 16'd3 : prime_p_reg;
                    a_next     = curve_a_reg;
                    state_next = S_RED_A;
                end
            end
            S_RED_A:
            begin
                if (su_rsp.done)
                begin
                    a_next     = su_r;
                    state_next = S_RED_X;
                end
            end
            S_RED_X:
            begin
                if (su_rsp.done)
                begin
                    px_next    = su_r;
                    qx_next    = su_r;
                    state_next = S_RED_Y;
                end
            end
            S_RED_Y:
            begin
                if (su_rsp.done)
                begin
                    py_next = su_r;
                    qy_next = su_r;
                    if (cnt_reg == 16'd0)
                    begin
                        status_next = ecsm_pkg::ST_ZERO;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 16'd1;
                        state_next = S_LOOP;
                    end
                end
            end
            S_LOOP:
            begin
                if (cnt_reg == 16'd0)
                begin
                    status_next = ecsm_pkg::ST_OK;
                    state_next  = S_FINISH;
                end
                else if (qx_reg == px_reg)
                begin
                    if ((qy_reg != py_reg) || (py_reg == '0))
                    begin
                        status_next = ecsm_pkg::ST_INF;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DBL_SQ;
                    end
                end
                else
                begin
                    num_next   = ecsm_pkg::sub_m(py_reg, qy_reg, m_reg);
                    r0_next    = m_reg;
                    r1_next    = ecsm_pkg::sub_m(px_reg, qx_reg, m_reg);
                    t0_next    = '0;
                    t1_next    = ecsm_pkg::fe_t'(1);
                    state_next = S_INV_CHK;
                end
            end
            S_DBL_SQ:
            begin
                // Numerator 3*x^2 before adding a; denominator 2*y.
                if (su_rsp.done)
                begin
                    num_next   = ecsm_pkg::add_m(t2, su_r, m_reg);
                    r0_next    = m_reg;
                    r1_next    = ecsm_pkg::add_m(py_reg, py_reg, m_reg);
                    t0_next    = '0;
                    t1_next    = ecsm_pkg::fe_t'(1);
                    state_next = S_DBL_A;
                end
            end
            S_DBL_A:
            begin
                num_next   = ecsm_pkg::add_m(num_reg, a_reg, m_reg);
                state_next = S_INV_CHK;
            end
            S_INV_CHK:
            begin
                if (r1_reg != '0)
                begin
                    state_next = S_INV_DIV;
                end
                else if (r0_reg != ecsm_pkg::fe_t'(1))
                begin
                    status_next = ecsm_pkg::ST_INF;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_LAM;
                end
            end
            S_INV_DIV:
            begin
                if (su_rsp.done)
                begin
                    q_next     = qm;
                    rr_next    = su_r;
                    state_next = S_INV_MUL;
                end
            end
            S_INV_MUL:
            begin
                if (su_rsp.done)
                begin
                    t1_next    = ecsm_pkg::sub_m(t0_reg, su_r, m_reg);
                    t0_next    = t1_reg;
                    r0_next    = r1_reg;
                    r1_next    = rr_reg;
                    state_next = S_INV_CHK;
                end
            end
            S_LAM:
            begin
                if (su_rsp.done)
                begin
                    lam_next   = su_r;
                    state_next = S_LSQ;
                end
            end
            S_LSQ:
            begin
                if (su_rsp.done)
                begin
                    x3_next    = ecsm_pkg::sub_m(ecsm_pkg::sub_m(su_r, qx_reg, m_reg),
                                                 px_reg, m_reg);
                    state_next = S_YMUL;
                end
            end
            S_YMUL:
            begin
                if (su_rsp.done)
                begin
                    qy_next    = ecsm_pkg::sub_m(su_r, qy_reg, m_reg);
                    qx_next    = x3_reg;
                    cnt_next   = cnt_reg - 16'd1;
                    state_next = S_LOOP;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = status_reg;
                    ox_next        = (status_reg == ecsm_pkg::ST_OK) ? qx_reg : 16'd0;
                    oy_next        = (status_reg == ecsm_pkg::ST_OK) ? qy_reg : 16'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            curve_a_reg   <= 16'd0;
            prime_p_reg   <= 16'd65521;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            curve_a_reg   <= curve_a_next;
            prime_p_reg   <= prime_p_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        a_reg      <= a_next;
        xin_reg    <= xin_next;
        yin_reg    <= yin_next;
        cnt_reg    <= cnt_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        num_reg    <= num_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        q_reg      <= q_next;
        rr_reg     <= rr_next;
        lam_reg    <= lam_next;
        x3_reg     <= x3_next;
        status_reg <= status_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ost_reg    <= ost_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = ost_reg;

    // Consistency checks.
    `ECSM_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tuser != ecsm_pkg::ST_OK), m_tdata == 32'd0, "failed result carries nonzero coordinates")
    `ECSM_ASSERT_IMP(a_start_idle, su_req.start, !su_rsp.busy, "serial unit started while busy")
    `ECSM_ASSERT_NXT(a_accept_go, s_fire, state_reg == S_RED_A, "accepted item did not start reduction")
    `ECSM_ASSERT_IMP(a_status_code, m_tvalid, m_tuser != 2'd3, "undefined status code on output")

endmodule
